// ===== sv/modmul_pkg.sv =====
`timescale 1ns / 1ps
// Shared types for the modular multiplier.
// No dependencies. Used by modmul_cell and modular_multiply_top.

package modmul_pkg;

  // Control bits that travel with each beat down the cell chain.
  typedef struct packed {
    logic valid;
    logic zero_mod;
  } ctl_t;

endpackage

// ===== sv/modmul_cell.sv =====
`timescale 1ns / 1ps
// One step of the modular multiplier chain: acc = (2*acc + bit*addend) mod m.
// Depends on modmul_pkg (ctl_t).

module modmul_cell #(
  parameter int W = 60
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  modmul_pkg::ctl_t    ctl_in,
  input  logic [W-1:0]        acc_in,
  input  logic [W-1:0]        addend_in,
  input  logic [W-1:0]        mod_in,
  input  logic [2*W-1:0]      bits_in,
  output modmul_pkg::ctl_t    ctl_out,
  output logic [W-1:0]        acc_out,
  output logic [W-1:0]        addend_out,
  output logic [W-1:0]        mod_out,
  output logic [2*W-1:0]      bits_out
);

  logic [W+1:0] sum;
  logic [W+1:0] mod_x1;
  logic [W+1:0] mod_x2;
  logic [W+1:0] red;
  logic [W-1:0] acc_next;

  // acc < m and addend < m, so sum < 3m: at most two subtractions of m.
  always_comb begin
    mod_x1 = {2'b00, mod_in};
    mod_x2 = {1'b0, mod_in, 1'b0};
    sum    = {1'b0, acc_in, 1'b0} + (bits_in[2*W-1] ? {2'b00, addend_in} : '0);
    if (sum >= mod_x2) begin
      red = sum - mod_x2;
    end else if (sum >= mod_x1) begin
      red = sum - mod_x1;
    end else begin
      red = sum;
    end
    acc_next = red[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_out    <= acc_next;
      addend_out <= addend_in;
      mod_out    <= mod_in;
      bits_out   <= {bits_in[2*W-2:0], 1'b0};
    end
  end

endmodule

// ===== sv/modular_multiply_top.sv =====
`timescale 1ns / 1ps
// Modular multiplier: product_mod = multiplicand * multiplier mod modulus.
// Chain of 2*OPERAND_BITS cells plus an output register; each cell does one bit.
// Throughput: one beat per cycle; the whole chain holds while the output stalls.
// Reset clears all valid bits; the chain comes out of reset empty.
// Depends on modmul_pkg and modmul_cell.

module modular_multiply_top #(
  parameter int OPERAND_BITS = 60
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OPERAND_BITS-1:0] multiplicand,
  input  logic [OPERAND_BITS-1:0] multiplier,
  input  logic [OPERAND_BITS-1:0] modulus,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [OPERAND_BITS-1:0] product_mod,
  output logic                    zero_modulus
);

  localparam int W      = OPERAND_BITS;
  localparam int NCELLS = 2 * W;

  modmul_pkg::ctl_t ctl_s    [0:NCELLS];
  logic [W-1:0]     acc_s    [0:NCELLS];
  logic [W-1:0]     addend_s [0:NCELLS];
  logic [W-1:0]     mod_s    [0:NCELLS];
  logic [2*W-1:0]   bits_s   [0:NCELLS];
  logic             advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // First W cells reduce the multiplicand (addend 1, bits of multiplicand),
  // the last W cells multiply (addend = reduced multiplicand, bits of multiplier).
  // Packed order of ctl_t: valid, then zero_mod.
  assign ctl_s[0]    = {in_valid, (modulus == '0)};
  assign acc_s[0]    = '0;
  assign addend_s[0] = W'(1);
  assign mod_s[0]    = modulus;
  assign bits_s[0]   = {multiplicand, multiplier};

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    logic [W-1:0] acc_in;
    logic [W-1:0] addend_in;

    if (k == W) begin : g_switch
      assign acc_in    = '0;
      assign addend_in = acc_s[k];
    end else begin : g_pass
      assign acc_in    = acc_s[k];
      assign addend_in = addend_s[k];
    end

    modmul_cell #(
      .W (W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (advance),
      .ctl_in     (ctl_s[k]),
      .acc_in     (acc_in),
      .addend_in  (addend_in),
      .mod_in     (mod_s[k]),
      .bits_in    (bits_s[k]),
      .ctl_out    (ctl_s[k+1]),
      .acc_out    (acc_s[k+1]),
      .addend_out (addend_s[k+1]),
      .mod_out    (mod_s[k+1]),
      .bits_out   (bits_s[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= ctl_s[NCELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      product_mod  <= ctl_s[NCELLS].zero_mod ? '0 : acc_s[NCELLS];
      zero_modulus <= ctl_s[NCELLS].zero_mod;
    end
  end

endmodule
